// ----- hw/rtl/rigf_pkg.sv -----
// rigf_pkg: shared types and constants for the RS485 idle-gap framer.
// Holds the item codes, bus modes, the queue command and the store write port.
// No dependencies.
package rigf_pkg;

    localparam int RX_DEPTH = 64;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int LEN_W    = 7;
    localparam int TIMER_W  = 17;
    localparam int HOLD_MS  = 1000;

    localparam logic [LEN_W-1:0]   RX_DEPTH_LEN  = LEN_W'(RX_DEPTH);
    localparam logic [TIMER_W-1:0] TIMER_MAX     = {TIMER_W{1'b1}};
    localparam logic [TIMER_W-1:0] HOLD_TIME     = TIMER_W'(HOLD_MS);
    localparam logic [15:0]        TIMEOUT_RESET = 16'd50;
    localparam logic [15:0]        TIMEOUT_MIN   = 16'd100;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_RX_CAP  = 2'd1,
        CFG_TX_CAP  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BUSY = 2'd1,
        MODE_XFER = 2'd2
    } bus_mode_t;

    typedef struct packed {
        logic             en;
        logic [RX_AW-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    typedef struct packed {
        logic             is_read;
        logic [LEN_W-1:0] len;
        logic [15:0]      accepted;
        logic             start;
        logic [15:0]      tcount;
        logic             ovf;
        logic             drive;
        bus_mode_t        link;
        logic             frame_ready;
    } cmd_t;

endpackage

// ----- hw/rtl/rigf_front.sv -----
// rigf_front: accepts items and config writes, owns all link state and
// turns each item into one queue command. Depends on rigf_pkg.
module rigf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_kind,
    input  logic [7:0]       s_rx_data,
    input  logic [9:0]       s_elapsed_ms,
    input  logic             s_uart_idle,
    input  logic [15:0]      s_size_limit,
    input  logic [15:0]      s_tx_count,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output rigf_pkg::cmd_t   cmd,
    output logic             cmd_push,
    input  logic             q_full,
    input  logic             burst_done,
    output rigf_pkg::mem_wr_t mem_wr
);
    import rigf_pkg::*;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                   input logic [9:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + {{(TIMER_W - 9){1'b0}}, d};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

    logic [LEN_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [LEN_W-1:0]   frame_len_reg, frame_len_next;
    logic [TIMER_W-1:0] rx_timer_reg, rx_timer_next;
    logic [TIMER_W-1:0] tx_timer_reg, tx_timer_next;
    bus_mode_t          mode_reg, mode_next;
    logic [15:0]        pending_reg, pending_next;
    logic               driver_reg, driver_next;
    logic [15:0]        timeout_reg, timeout_next;
    logic [TIMER_W-1:0] hold_end_reg, hold_end_next;
    logic [LEN_W-1:0]   rx_cap_reg, rx_cap_next;
    logic [15:0]        tx_cap_reg, tx_cap_next;
    logic               read_pend_reg, read_pend_next;

    logic               accept;
    logic [TIMER_W-1:0] timeout_ext;
    logic [TIMER_W-1:0] rx_sum;
    logic [LEN_W-1:0]   rd_len;
    logic [15:0]        acc;
    logic [15:0]        to_val;
    logic [LEN_W-1:0]   cap_val;

    assign s_ready     = !read_pend_reg && !q_full;
    assign cfg_ready   = 1'b1;
    assign accept      = s_valid && s_ready;
    assign cmd_push    = accept;
    assign timeout_ext = {1'b0, timeout_reg};

    always_comb begin
        wr_idx_next    = wr_idx_reg;
        frame_len_next = frame_len_reg;
        rx_timer_next  = rx_timer_reg;
        tx_timer_next  = tx_timer_reg;
        mode_next      = mode_reg;
        pending_next   = pending_reg;
        driver_next    = driver_reg;
        timeout_next   = timeout_reg;
        hold_end_next  = hold_end_reg;
        rx_cap_next    = rx_cap_reg;
        tx_cap_next    = tx_cap_reg;
        read_pend_next = read_pend_reg && !burst_done;
        rx_sum         = '0;
        rd_len         = '0;
        acc            = '0;
        to_val         = '0;
        cap_val        = '0;
        mem_wr         = '0;
        cmd            = '0;

        if (accept) begin
            unique case (kind_t'(s_kind))
                KIND_BYTE: begin
                    if (rx_cap_reg != '0) begin
                        if (wr_idx_reg >= rx_cap_reg) begin
                            cmd.ovf = 1'b1;
                        end else begin
                            mem_wr.en     = 1'b1;
                            mem_wr.addr   = wr_idx_reg[RX_AW-1:0];
                            mem_wr.data   = s_rx_data;
                            wr_idx_next   = wr_idx_reg + 1'b1;
                            rx_timer_next = '0;
                        end
                    end
                end
                KIND_TICK: begin
                    // receive side: idle gap, then latch, then hold
                    if (rx_timer_reg < timeout_ext) begin
                        rx_timer_next = sat_add(rx_timer_reg, s_elapsed_ms);
                    end else if (wr_idx_reg != '0) begin
                        if (frame_len_reg == '0) begin
                            frame_len_next = wr_idx_reg;
                        end else if (rx_timer_reg < hold_end_reg) begin
                            rx_sum        = sat_add(rx_timer_reg, s_elapsed_ms);
                            rx_timer_next = rx_sum;
                            if (rx_sum >= hold_end_reg) begin
                                wr_idx_next = '0;
                            end
                        end
                    end
                    // transmit side: turnaround, then start or release
                    if (tx_timer_reg < timeout_ext) begin
                        tx_timer_next = sat_add(tx_timer_reg, s_elapsed_ms);
                    end else if (s_uart_idle) begin
                        if (mode_reg == MODE_XFER) begin
                            driver_next  = 1'b0;
                            mode_next    = MODE_IDLE;
                            pending_next = '0;
                        end else if (pending_reg != '0) begin
                            driver_next = 1'b1;
                            mode_next   = MODE_XFER;
                            cmd.start   = 1'b1;
                            cmd.tcount  = pending_reg;
                        end
                    end
                end
                KIND_READ: begin
                    if (rx_cap_reg != '0 && frame_len_reg != '0) begin
                        if (s_size_limit < {{(16 - LEN_W){1'b0}}, frame_len_reg}) begin
                            rd_len = s_size_limit[LEN_W-1:0];
                        end else begin
                            rd_len = frame_len_reg;
                        end
                        wr_idx_next    = '0;
                        frame_len_next = '0;
                    end
                    cmd.is_read = rd_len != '0;
                    cmd.len     = rd_len;
                    if (rd_len != '0) begin
                        read_pend_next = 1'b1;
                    end
                end
                KIND_WRITE: begin
                    if (tx_cap_reg != '0 && mode_reg == MODE_IDLE) begin
                        acc           = (s_tx_count > tx_cap_reg) ? tx_cap_reg : s_tx_count;
                        mode_next     = MODE_BUSY;
                        pending_next  = acc;
                        tx_timer_next = '0;
                    end
                    cmd.accepted = acc;
                end
            endcase
        end

        cmd.drive       = driver_next;
        cmd.link        = mode_next;
        cmd.frame_ready = frame_len_next != '0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TIMEOUT: begin
                    to_val        = (cfg_data < TIMEOUT_MIN) ? TIMEOUT_MIN : cfg_data;
                    timeout_next  = to_val;
                    hold_end_next = {1'b0, to_val} + HOLD_TIME;
                end
                CFG_RX_CAP: begin
                    cap_val        = cfg_data[LEN_W-1:0];
                    rx_cap_next    = (cap_val > RX_DEPTH_LEN) ? RX_DEPTH_LEN : cap_val;
                    wr_idx_next    = '0;
                    frame_len_next = '0;
                    rx_timer_next  = '0;
                end
                CFG_TX_CAP: begin
                    tx_cap_next   = cfg_data;
                    mode_next     = MODE_IDLE;
                    pending_next  = '0;
                    tx_timer_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            frame_len_reg <= '0;
            rx_timer_reg  <= '0;
            tx_timer_reg  <= '0;
            mode_reg      <= MODE_IDLE;
            pending_reg   <= '0;
            driver_reg    <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            hold_end_reg  <= {1'b0, TIMEOUT_RESET} + HOLD_TIME;
            rx_cap_reg    <= '0;
            tx_cap_reg    <= '0;
            read_pend_reg <= 1'b0;
        end else begin
            wr_idx_reg    <= wr_idx_next;
            frame_len_reg <= frame_len_next;
            rx_timer_reg  <= rx_timer_next;
            tx_timer_reg  <= tx_timer_next;
            mode_reg      <= mode_next;
            pending_reg   <= pending_next;
            driver_reg    <= driver_next;
            timeout_reg   <= timeout_next;
            hold_end_reg  <= hold_end_next;
            rx_cap_reg    <= rx_cap_next;
            tx_cap_reg    <= tx_cap_next;
            read_pend_reg <= read_pend_next;
        end
    end

    // the store must stay frozen while the back end streams a frame
    a_no_write_during_read: assert property (@(posedge aclk) disable iff (!aresetn)
        read_pend_reg |-> !mem_wr.en)
        else $error("store written while a frame read is in flight");

endmodule

// ----- hw/rtl/rigf_queue.sv -----
// rigf_queue: two-entry command queue between the front and back ends.
// Depends on rigf_pkg.
module rigf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rigf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output rigf_pkg::cmd_t head_cmd,
    output logic           empty
);
    import rigf_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    cmd_t            slot_mem [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;

    assign full     = cnt_reg == QC_W'(Q_DEPTH);
    assign empty    = cnt_reg == '0;
    assign head_cmd = slot_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("command popped from an empty queue");

endmodule

// ----- hw/rtl/rigf_back.sv -----
// rigf_back: holds the receive store and the result register; plays out
// queue commands, streaming read bursts from the store. Depends on rigf_pkg.
module rigf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  rigf_pkg::cmd_t    q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    input  rigf_pkg::mem_wr_t mem_wr,
    output logic              burst_done,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_data_byte,
    output logic              m_byte_valid,
    output logic [6:0]        m_read_length,
    output logic              m_last,
    output logic [15:0]       m_accepted_count,
    output logic              m_start_transfer,
    output logic [15:0]       m_transfer_count,
    output logic              m_drive_enable,
    output logic [1:0]        m_link_state,
    output logic              m_frame_ready,
    output logic              m_overflow
);
    import rigf_pkg::*;

    logic [7:0]       store_mem [RX_DEPTH];
    logic [7:0]       rd_q;

    logic             out_valid_reg, out_valid_next;
    logic             byte_valid_reg, byte_valid_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      accepted_reg, accepted_next;
    logic             start_reg, start_next;
    logic [15:0]      tcount_reg, tcount_next;
    logic             ovf_reg, ovf_next;
    logic             drive_reg, drive_next;
    bus_mode_t        link_reg, link_next;
    logic             frame_ready_reg, frame_ready_next;
    logic [RX_AW-1:0] idx_reg, idx_next;

    logic             out_free;
    logic             burst_cont;
    logic [RX_AW-1:0] idx_inc;

    assign out_free   = !out_valid_reg || m_ready;
    assign burst_cont = out_valid_reg && byte_valid_reg && !last_reg;
    assign burst_done = out_valid_reg && m_ready && byte_valid_reg && last_reg;
    assign idx_inc    = idx_reg + 1'b1;

    always_comb begin
        out_valid_next   = out_valid_reg;
        byte_valid_next  = byte_valid_reg;
        last_next        = last_reg;
        len_next         = len_reg;
        accepted_next    = accepted_reg;
        start_next       = start_reg;
        tcount_next      = tcount_reg;
        ovf_next         = ovf_reg;
        drive_next       = drive_reg;
        link_next        = link_reg;
        frame_ready_next = frame_ready_reg;
        idx_next         = idx_reg;
        q_pop            = 1'b0;

        if (out_free) begin
            priority if (burst_cont) begin
                // advance to the next frame byte
                idx_next  = idx_inc;
                last_next = (LEN_W'(idx_inc) + 1'b1) == len_reg;
            end else if (!q_empty) begin
                q_pop            = 1'b1;
                out_valid_next   = 1'b1;
                byte_valid_next  = q_cmd.is_read;
                last_next        = q_cmd.is_read ? (q_cmd.len == LEN_W'(1)) : 1'b1;
                len_next         = q_cmd.len;
                accepted_next    = q_cmd.accepted;
                start_next       = q_cmd.start;
                tcount_next      = q_cmd.tcount;
                ovf_next         = q_cmd.ovf;
                drive_next       = q_cmd.drive;
                link_next        = q_cmd.link;
                frame_ready_next = q_cmd.frame_ready;
                idx_next         = '0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    // store: one write port from the front end, registered read at the next index
    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            store_mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_q <= store_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
        byte_valid_reg  <= byte_valid_next;
        last_reg        <= last_next;
        len_reg         <= len_next;
        accepted_reg    <= accepted_next;
        start_reg       <= start_next;
        tcount_reg      <= tcount_next;
        ovf_reg         <= ovf_next;
        drive_reg       <= drive_next;
        link_reg        <= link_next;
        frame_ready_reg <= frame_ready_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_data_byte      = byte_valid_reg ? rd_q : 8'd0;
    assign m_byte_valid     = byte_valid_reg;
    assign m_read_length    = len_reg;
    assign m_last           = last_reg;
    assign m_accepted_count = accepted_reg;
    assign m_start_transfer = start_reg;
    assign m_transfer_count = tcount_reg;
    assign m_drive_enable   = drive_reg;
    assign m_link_state     = link_reg;
    assign m_frame_ready    = frame_ready_reg;
    assign m_overflow       = ovf_reg;

    a_burst_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && byte_valid_reg && !last_reg && m_ready)
        |=> (out_valid_reg && byte_valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("read burst did not advance by one byte");

endmodule

// ----- hw/rtl/rs485_idle_gap_framer.sv -----
// rs485_idle_gap_framer: top level of the RS485 idle-gap framer and link manager.
// Throughput: one item per clock for bytes, ticks and writes while the queue has
// room; a read of n bytes gives n result beats, one per clock while m_ready is
// high, and holds s_ready low until its last beat is taken.
// Reset (aresetn low, synchronous): clears all link state and config to defaults;
// the 64-byte receive store is not cleared and holds garbage until written.
module rs485_idle_gap_framer (
    input  logic        aclk,
    input  logic        aresetn,
    // item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_rx_data,
    input  logic [9:0]  s_elapsed_ms,
    input  logic        s_uart_idle,
    input  logic [15:0] s_size_limit,
    input  logic [15:0] s_tx_count,
    // config write channel, always ready
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_byte_valid,
    output logic [6:0]  m_read_length,
    output logic        m_last,
    output logic [15:0] m_accepted_count,
    output logic        m_start_transfer,
    output logic [15:0] m_transfer_count,
    output logic        m_drive_enable,
    output logic [1:0]  m_link_state,
    output logic        m_frame_ready,
    output logic        m_overflow
);
    import rigf_pkg::*;

    // Front end: takes every item beat, updates timers, frame and bus state,
    // writes received bytes into the store and pushes one command per item.
    cmd_t    push_cmd;
    logic    cmd_push;
    logic    q_full;
    logic    burst_done;
    mem_wr_t mem_wr;

    // Queue output toward the back end.
    cmd_t    head_cmd;
    logic    q_empty;
    logic    q_pop;

    rigf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_rx_data    (s_rx_data),
        .s_elapsed_ms (s_elapsed_ms),
        .s_uart_idle  (s_uart_idle),
        .s_size_limit (s_size_limit),
        .s_tx_count   (s_tx_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (push_cmd),
        .cmd_push     (cmd_push),
        .q_full       (q_full),
        .burst_done   (burst_done),
        .mem_wr       (mem_wr)
    );

    // Decouple: lets the front take the next beat while a result waits on m_ready.
    rigf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // Back end: drives the result register; a read command streams its bytes
    // out of the store and reports the last beat so the front can resume.
    rigf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_cmd            (head_cmd),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .mem_wr           (mem_wr),
        .burst_done       (burst_done),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_byte_valid     (m_byte_valid),
        .m_read_length    (m_read_length),
        .m_last           (m_last),
        .m_accepted_count (m_accepted_count),
        .m_start_transfer (m_start_transfer),
        .m_transfer_count (m_transfer_count),
        .m_drive_enable   (m_drive_enable),
        .m_link_state     (m_link_state),
        .m_frame_ready    (m_frame_ready),
        .m_overflow       (m_overflow)
    );

endmodule

// ----- test/tb_rs485_idle_gap_framer.sv -----
// tb_rs485_idle_gap_framer: self-checking testbench for the RS485 idle-gap framer.
// Holds the link scoreboard class (its own model of the framer) and the top module.
// Depends on rigf_pkg and the rs485_idle_gap_framer RTL.

import rigf_pkg::*;

typedef struct packed {
    kind_t       kind;
    logic [7:0]  rx_data;
    logic [9:0]  elapsed_ms;
    logic        uart_idle;
    logic [15:0] size_limit;
    logic [15:0] tx_count;
} link_item_t;

typedef struct packed {
    logic [7:0]       data_byte;
    logic             byte_valid;
    logic [LEN_W-1:0] read_length;
    logic             last;
    logic [15:0]      accepted_count;
    logic             start_transfer;
    logic [15:0]      transfer_count;
    logic             drive_enable;
    bus_mode_t        link_state;
    logic             frame_ready;
    logic             overflow;
} link_beat_t;

typedef logic [15:0] beat_fields_t [11];

class link_scoreboard;
    link_beat_t  expected_beats[$];
    logic [7:0]  rx_store [RX_DEPTH];
    int unsigned wr_idx, frame_len, rx_gap_ms, turn_ms, pending;
    int unsigned timeout_ms, rx_cap, tx_cap;
    bus_mode_t   mode;
    logic        driver_on;
    int          errors, beats_seen;
    string       field_names [11] = '{"data_byte", "byte_valid", "read_length", "last",
                                      "accepted_count", "start_transfer", "transfer_count",
                                      "drive_enable", "link_state", "frame_ready", "overflow"};

    function new();
        wr_idx     = 0;
        frame_len  = 0;
        rx_gap_ms  = 0;
        turn_ms    = 0;
        pending    = 0;
        timeout_ms = TIMEOUT_RESET;
        rx_cap     = 0;
        tx_cap     = 0;
        mode       = MODE_IDLE;
        driver_on  = 1'b0;
        errors     = 0;
        beats_seen = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 50)
            $display("MISMATCH: %s", msg);
    endtask

    function int unsigned sat_ms(int unsigned t, int unsigned d);
        int unsigned s;
        s = t + d;
        return (s > TIMER_MAX) ? int'(TIMER_MAX) : s;
    endfunction

    // Status fields reflect the state after the item.
    function link_beat_t status_beat();
        link_beat_t b;
        b              = '0;
        b.last         = 1'b1;
        b.drive_enable = driver_on;
        b.link_state   = mode;
        b.frame_ready  = (frame_len != 0);
        return b;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            CFG_TIMEOUT: begin
                timeout_ms = (data < TIMEOUT_MIN) ? TIMEOUT_MIN : data;
            end
            CFG_RX_CAP: begin
                rx_cap    = (data[6:0] > RX_DEPTH) ? RX_DEPTH : data[6:0];
                wr_idx    = 0;
                frame_len = 0;
                rx_gap_ms = 0;
            end
            CFG_TX_CAP: begin
                tx_cap  = data;
                mode    = MODE_IDLE;
                pending = 0;
                turn_ms = 0;
            end
            default: ;
        endcase
    endfunction

    function void predict_beats(link_item_t it);
        link_beat_t  b;
        int unsigned len, hold_end, accepted;
        logic        ovf, start;
        int unsigned tcount;
        ovf    = 1'b0;
        start  = 1'b0;
        tcount = 0;
        case (it.kind)
            KIND_BYTE: begin
                if (rx_cap != 0) begin
                    if (wr_idx >= rx_cap) begin
                        ovf = 1'b1;
                    end else begin
                        rx_store[wr_idx] = it.rx_data;
                        wr_idx++;
                        rx_gap_ms = 0;
                    end
                end
                b = status_beat();
                b.overflow = ovf;
                expected_beats.push_back(b);
            end
            KIND_TICK: begin
                hold_end = timeout_ms + HOLD_MS;
                if (rx_gap_ms < timeout_ms) begin
                    rx_gap_ms = sat_ms(rx_gap_ms, it.elapsed_ms);
                end else if (wr_idx != 0) begin
                    if (frame_len == 0) begin
                        frame_len = wr_idx;
                    end else if (rx_gap_ms < hold_end) begin
                        rx_gap_ms = sat_ms(rx_gap_ms, it.elapsed_ms);
                        if (rx_gap_ms >= hold_end)
                            wr_idx = 0;
                    end
                end
                if (turn_ms < timeout_ms) begin
                    turn_ms = sat_ms(turn_ms, it.elapsed_ms);
                end else if (it.uart_idle) begin
                    if (mode == MODE_XFER) begin
                        driver_on = 1'b0;
                        mode      = MODE_IDLE;
                        pending   = 0;
                    end
                    if (pending != 0) begin
                        driver_on = 1'b1;
                        mode      = MODE_XFER;
                        start     = 1'b1;
                        tcount    = pending;
                    end
                end
                b = status_beat();
                b.start_transfer = start;
                b.transfer_count = tcount[15:0];
                expected_beats.push_back(b);
            end
            KIND_READ: begin
                len = 0;
                if (rx_cap != 0 && frame_len != 0) begin
                    len = (frame_len < it.size_limit) ? frame_len : it.size_limit;
                    if (len > RX_DEPTH)
                        len = RX_DEPTH;
                    wr_idx    = 0;
                    frame_len = 0;
                end
                if (len == 0) begin
                    expected_beats.push_back(status_beat());
                end else begin
                    for (int k = 0; k < len; k++) begin
                        b             = status_beat();
                        b.data_byte   = rx_store[k];
                        b.byte_valid  = 1'b1;
                        b.read_length = len[LEN_W-1:0];
                        b.last        = (k == len - 1);
                        expected_beats.push_back(b);
                    end
                end
            end
            default: begin
                accepted = 0;
                if (tx_cap != 0 && mode == MODE_IDLE) begin
                    accepted = (it.tx_count > tx_cap) ? tx_cap : it.tx_count;
                    mode     = MODE_BUSY;
                    pending  = accepted;
                    turn_ms  = 0;
                end
                b = status_beat();
                b.accepted_count = accepted[15:0];
                expected_beats.push_back(b);
            end
        endcase
    endfunction

    function beat_fields_t fields_of(link_beat_t b);
        beat_fields_t f;
        f = '{b.data_byte, b.byte_valid, b.read_length, b.last, b.accepted_count,
              b.start_transfer, b.transfer_count, b.drive_enable, b.link_state,
              b.frame_ready, b.overflow};
        return f;
    endfunction

    task check_beat(link_beat_t got);
        link_beat_t   want;
        beat_fields_t g, w;
        beats_seen++;
        if (expected_beats.size() == 0) begin
            report($sformatf("result beat %0d arrived with nothing expected", beats_seen));
            return;
        end
        want = expected_beats.pop_front();
        g    = fields_of(got);
        w    = fields_of(want);
        foreach (g[i]) begin
            if (g[i] !== w[i])
                report($sformatf("result beat %0d %s: got %0h, expected %0h",
                                 beats_seen, field_names[i], g[i], w[i]));
        end
    endtask
endclass

module tb_rs485_idle_gap_framer;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Config index that names no register; a write there must change nothing.
    localparam logic [1:0] CFG_NONE = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_rx_data;
    logic [9:0]  s_elapsed_ms;
    logic        s_uart_idle;
    logic [15:0] s_size_limit;
    logic [15:0] s_tx_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data_byte;
    logic        m_byte_valid;
    logic [6:0]  m_read_length;
    logic        m_last;
    logic [15:0] m_accepted_count;
    logic        m_start_transfer;
    logic [15:0] m_transfer_count;
    logic        m_drive_enable;
    logic [1:0]  m_link_state;
    logic        m_frame_ready;
    logic        m_overflow;

    link_scoreboard sb;
    link_beat_t     seen_beat;
    int             quiet_cycles = 0;
    int             items_sent   = 0;
    int             burst_left   = 0;
    bit             gaps_on      = 1'b1;
    logic [15:0]    ready_pat;
    int             pat_left;

    rs485_idle_gap_framer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_rx_data        (s_rx_data),
        .s_elapsed_ms     (s_elapsed_ms),
        .s_uart_idle      (s_uart_idle),
        .s_size_limit     (s_size_limit),
        .s_tx_count       (s_tx_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_byte_valid     (m_byte_valid),
        .m_read_length    (m_read_length),
        .m_last           (m_last),
        .m_accepted_count (m_accepted_count),
        .m_start_transfer (m_start_transfer),
        .m_transfer_count (m_transfer_count),
        .m_drive_enable   (m_drive_enable),
        .m_link_state     (m_link_state),
        .m_frame_ready    (m_frame_ready),
        .m_overflow       (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall on a rotating pattern, reloaded now and then. Some patterns
    // are all ones (no stalls), some sparse; bit 15 is forced so that within one
    // pattern every rotation holds at least one ready cycle.
    initial begin
        m_ready   = 1'b0;
        ready_pat = '1;
        pat_left  = 0;
        forever begin
            @(negedge aclk);
            if (pat_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = '1;
                    1:       ready_pat = 16'($urandom & $urandom);
                    default: ready_pat = 16'($urandom);
                endcase
                ready_pat[15] = 1'b1;
                pat_left      = $urandom_range(16, 200);
            end
            m_ready   = ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            pat_left--;
        end
    end

    // Check every result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_beat = '{m_data_byte, m_byte_valid, m_read_length, m_last,
                          m_accepted_count, m_start_transfer, m_transfer_count,
                          m_drive_enable, bus_mode_t'(m_link_state), m_frame_ready,
                          m_overflow};
            sb.check_beat(seen_beat);
        end
    end

    // Count cycles in which no channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic link_item_t rand_item(kind_t k);
        link_item_t it;
        it.kind       = k;
        it.rx_data    = 8'($urandom);
        it.elapsed_ms = 10'($urandom_range(0, 1000));
        it.uart_idle  = 1'($urandom);
        it.size_limit = 16'($urandom);
        it.tx_count   = 16'($urandom);
        return it;
    endfunction

    // Present one item and hold it until the block takes the beat. Between
    // bursts drop valid for a random gap.
    task automatic send_item(link_item_t it);
        if (gaps_on && burst_left <= 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_kind       = it.kind;
        s_rx_data    = it.rx_data;
        s_elapsed_ms = it.elapsed_ms;
        s_uart_idle  = it.uart_idle;
        s_size_limit = it.size_limit;
        s_tx_count   = it.tx_count;
        do @(posedge aclk); while (!s_ready);
        sb.predict_beats(it);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_byte(logic [7:0] d);
        link_item_t it;
        it         = rand_item(KIND_BYTE);
        it.rx_data = d;
        send_item(it);
    endtask

    task automatic send_tick(int unsigned ms, logic uart_idle);
        link_item_t it;
        it            = rand_item(KIND_TICK);
        it.elapsed_ms = 10'(ms);
        it.uart_idle  = uart_idle;
        send_item(it);
    endtask

    task automatic send_read(logic [15:0] limit);
        link_item_t it;
        it            = rand_item(KIND_READ);
        it.size_limit = limit;
        send_item(it);
    endtask

    task automatic send_write(logic [15:0] count);
        link_item_t it;
        it          = rand_item(KIND_WRITE);
        it.tx_count = count;
        send_item(it);
    endtask

    // Hold the sender off until every expected beat is in, then let the
    // pipeline settle so that a register write finds the block idle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic rand_idle();
        return ($urandom_range(0, 3) != 0);
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2, 3: return 16'($urandom);
            4:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 80));
        endcase
    endfunction

    function automatic logic [15:0] pick_max(int unsigned n);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2:    return 16'($urandom_range(1, n));
            3:       return 16'($urandom);
            4:       return 16'(n);
            default: return 16'hFFFF;
        endcase
    endfunction

    // One well-formed frame: maybe a transmit request, a burst of bytes, ticks
    // until the idle gap latches the frame, maybe a stale hold or extra byte, then a read.
    task automatic run_frame();
        int unsigned cap, nbytes, step_lo, step, gap_ms;
        cap = sb.rx_cap;
        if ($urandom_range(0, 9) < 4)
            send_write(pick_count());
        if (cap == 0)
            nbytes = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0)
            nbytes = cap + $urandom_range(0, 2);
        else
            nbytes = $urandom_range(1, (cap < 12) ? cap : 12);
        repeat (nbytes) send_byte(8'($urandom));
        step_lo = sb.timeout_ms / 4;
        if (step_lo > 1000)
            step_lo = 1000;
        if (step_lo == 0)
            step_lo = 1;
        gap_ms = 0;
        while (gap_ms < sb.timeout_ms) begin
            step = $urandom_range(step_lo, 1000);
            send_tick(step, rand_idle());
            gap_ms += step;
        end
        send_tick($urandom_range(0, 1000), rand_idle());
        // Let the frame go stale: the write index clears, the length stays.
        if ($urandom_range(0, 6) == 0) begin
            repeat (2) send_tick(1000, rand_idle());
            if ($urandom_range(0, 1) == 0)
                send_byte(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom));
        send_read(pick_max(nbytes));
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 3)) send_item(rand_item(kind_t'($urandom_range(0, 3))));
    endtask

    task automatic run_phase(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 75)
                run_frame();
            else
                run_noise();
            if ($urandom_range(0, 9) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_BYTE;
        s_rx_data    = '0;
        s_elapsed_ms = '0;
        s_uart_idle  = 1'b0;
        s_size_limit = '0;
        s_tx_count   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TIMEOUT;
        cfg_data     = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset defaults: no store, so the byte is ignored and the read is empty.
        send_byte(8'h81);
        send_read(16'hFFFF);
        wait_idle();

        // Directed part: timeout 0 clamps up, capacity above the store clamps down.
        write_reg(CFG_TIMEOUT, 16'h0000);
        write_reg(CFG_RX_CAP, 16'h007F);
        write_reg(CFG_TX_CAP, 16'hFFFF);
        send_read(16'hFFFF);                // nothing latched yet
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_tick(1000, 1'b1);
        send_tick(1, 1'b1);                 // gap reached, latch the frame
        send_read(16'h0000);                // zero-size read still drops the frame
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_tick(1000, 1'b1);
        send_tick(0, 1'b1);
        send_read(16'h0001);                // clip to one byte
        send_write(16'hFFFF);
        send_write(16'h0007);               // refused, bus busy
        send_tick(1000, 1'b0);
        send_tick(500, 1'b0);               // UART busy past turnaround
        send_tick(1, 1'b1);                 // start transfer, driver on
        send_tick(1, 1'b1);                 // UART idle again, release driver
        send_write(16'h0000);               // zero write: busy until tx_capacity write
        send_tick(1000, 1'b1);
        send_byte(8'h11);
        send_tick(1000, 1'b1);
        send_tick(0, 1'b1);
        send_tick(200, 1'b1);               // hold expires, write index clears
        send_read(16'hFFFF);                // stale frame is still readable
        wait_idle();

        // Small receive store, modest transmit buffer.
        write_reg(CFG_TIMEOUT, 16'd99);
        write_reg(CFG_RX_CAP, 16'd16);
        write_reg(CFG_TX_CAP, 16'd40);
        run_phase(60);

        // One-byte store overflows constantly; no transmit buffer refuses writes.
        write_reg(CFG_RX_CAP, 16'd1);
        write_reg(CFG_TX_CAP, 16'd0);
        write_reg(CFG_TIMEOUT, 16'($urandom_range(150, 400)));
        run_phase(35);

        // Full store, random buffer, sender with no gaps.
        gaps_on = 1'b0;
        write_reg(CFG_TIMEOUT, 16'($urandom_range(100, 800)));
        write_reg(CFG_RX_CAP, 16'd64);
        write_reg(CFG_TX_CAP, 16'($urandom_range(1, 65535)));
        run_phase(40);
        gaps_on = 1'b1;

        // Longest timeout, no store, one-byte buffer, and a write to no register.
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_RX_CAP, 16'd0);
        write_reg(CFG_TX_CAP, 16'd1);
        write_reg(CFG_NONE, 16'($urandom));
        run_phase(30);

        // Shortest timeout, capacity written with upper bits set, small buffer.
        write_reg(CFG_TIMEOUT, 16'd100);
        write_reg(CFG_RX_CAP, 16'hFF80 | 16'($urandom_range(2, 63)));
        write_reg(CFG_TX_CAP, 16'($urandom_range(1, 16)));
        run_phase(65);

        repeat (10) @(posedge aclk);
        if (sb.expected_beats.size() != 0)
            sb.report($sformatf("%0d result beats never arrived", sb.expected_beats.size()));
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rigf_pkg.sv
hw/rtl/rigf_front.sv
hw/rtl/rigf_queue.sv
hw/rtl/rigf_back.sv
hw/rtl/rs485_idle_gap_framer.sv
test/tb_rs485_idle_gap_framer.sv
